### rtl/nic_pkg.sv
// Shared types and constants for the normalized image convolution block.
// No dependencies; every other file in rtl/ but nic_linebuf.sv uses this package.
package nic_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_KERNEL_DEF  = 5;
  localparam int LINE_MAX_DEF    = 4096;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Port field widths
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int TAP_W      = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE    = 3'd6;

  // Register reset values
  localparam logic [11:0] SHAPE_RST  = 12'd603;
  localparam logic [12:0] LINE_W_RST = 13'd4096;
  localparam logic [9:0]  LAYOUT_RST = 10'd8;

  // Channel operation codes; the reserved code acts as nop
  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_COPY = 2'd1;
  localparam logic [1:0] OP_CONV = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] pix_ch0;
    logic [FIELD_W-1:0] pix_ch1;
    logic [FIELD_W-1:0] pix_ch2;
    logic [FIELD_W-1:0] pix_ch3;
    logic               frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] res_ch0;
    logic [FIELD_W-1:0] res_ch1;
    logic [FIELD_W-1:0] res_ch2;
    logic [FIELD_W-1:0] res_ch3;
    logic               row_end;
  } pix_out_t;

  // Sequencer to lane control
  typedef struct packed {
    logic clr;
    logic mac;
    logic origin;
    logic div_ld;
    logic div_step;
  } lane_ctrl_t;

endpackage

### rtl/normalized_image_convolution.sv
// Normalized 2-D convolution, one pixel request at a time.
// Steps: accept with line-store read, window load and line-store update,
// MAC walk over the kw*kh taps, divider load, bit-serial divide, merge.
// Input stalls until the request is done, also while a result waits for
// the output register; a pixel that does not emit skips MAC and divide.
// Reset is asynchronous active low; line store contents undefined until written.
module normalized_image_convolution #(
  parameter int MAX_KERNEL  = nic_pkg::MAX_KERNEL_DEF,
  parameter int LINE_MAX    = nic_pkg::LINE_MAX_DEF,
  parameter int CHANNELS    = nic_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = nic_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nic_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nic_pkg::pix_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nic_pkg::pix_out_t              out_data_o
);
  import nic_pkg::*;

  localparam int NWIN   = MAX_KERNEL * MAX_KERNEL;
  localparam int WIN_IW = (NWIN > 1) ? $clog2(NWIN) : 1;
  localparam int CW     = $clog2(LINE_MAX + 1);
  localparam int AW     = $clog2(LINE_MAX);
  localparam int RW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int WORD_W = CHANNELS * SAMPLE_BITS;
  localparam int LS_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int DW     = 8 + $clog2(NWIN);
  localparam int ACC_W  = SAMPLE_BITS + 8 + $clog2(NWIN);
  localparam int DCW    = $clog2(ACC_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DVLD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // configuration registers
  logic [CFG_DATA_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic [11:0]           shape_q;
  logic [12:0]           line_w_q;
  logic [9:0]            layout_q;
  logic                  wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      shape_q  <= SHAPE_RST;
      line_w_q <= LINE_W_RST;
      layout_q <= LAYOUT_RST;
      wide_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        REG_COEF_C: coef_c_q <= cfg_data_i;
        REG_SHAPE:  shape_q  <= cfg_data_i[11:0];
        REG_LINE_W: line_w_q <= cfg_data_i[12:0];
        REG_LAYOUT: layout_q <= cfg_data_i[9:0];
        REG_WIDE:   wide_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // decoded window geometry
  function automatic logic [2:0] clamp_dim(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (int'(v) > MAX_KERNEL) return 3'(MAX_KERNEL);
    return v;
  endfunction

  logic [2:0]    kw, kh, ox, oy, r0, c0;
  logic [CW-1:0] lw;

  always_comb begin
    kw = clamp_dim(shape_q[2:0]);
    kh = clamp_dim(shape_q[5:3]);
    ox = (shape_q[8:6] >= kw) ? kw - 3'd1 : shape_q[8:6];
    oy = (shape_q[11:9] >= kh) ? kh - 3'd1 : shape_q[11:9];
    r0 = 3'(MAX_KERNEL) - kh;
    c0 = 3'(MAX_KERNEL) - kw;
    if (line_w_q == '0) begin
      lw = CW'(1);
    end else if (int'(line_w_q) > LINE_MAX) begin
      lw = CW'(LINE_MAX);
    end else begin
      lw = CW'(line_w_q);
    end
  end

  // sequencer state
  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  rows_q, rows_d;
  logic [CW-1:0]  cur_col_q;
  logic           emit_q, row_end_q;
  logic [WORD_W-1:0] word_q;
  logic [2:0]     y_q, x_q;
  logic [DCW-1:0] dcnt_q;
  logic signed [DW-1:0] dsum_q;
  logic           accept, merge_load;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign merge_load = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  // column and row bookkeeping for the incoming pixel
  logic [CW-1:0] cc;
  logic [RW-1:0] rs;
  logic          emit_now, row_end_now;

  always_comb begin
    cc = in_data_i.frame_start ? '0 : col_q;
    rs = in_data_i.frame_start ? '0 : rows_q;
    if (cc >= lw) begin
      cc = '0;
      if (int'(rs) < MAX_KERNEL - 1) rs = rs + RW'(1);
    end
    emit_now    = ({1'b0, cc} + (CW+1)'(1) >= (CW+1)'(kw)) &&
                  (4'(rs) + 4'd1 >= 4'(kh));
    row_end_now = ({1'b0, cc} + (CW+1)'(1) == {1'b0, lw});
    if ({1'b0, cc} + (CW+1)'(1) >= {1'b0, lw}) begin
      col_d  = '0;
      rows_d = (int'(rs) < MAX_KERNEL - 1) ? rs + RW'(1) : rs;
    end else begin
      col_d  = cc + CW'(1);
      rows_d = rs;
    end
  end

  // sample masking of the incoming pixel
  logic [FIELD_W-1:0] pix [4];
  logic [WORD_W-1:0]  word_in;
  assign pix[0] = in_data_i.pix_ch0;
  assign pix[1] = in_data_i.pix_ch1;
  assign pix[2] = in_data_i.pix_ch2;
  assign pix[3] = in_data_i.pix_ch3;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      word_in[c*SAMPLE_BITS +: SAMPLE_BITS] = wide_q ? pix[c][SAMPLE_BITS-1:0]
                                             : SAMPLE_BITS'(pix[c][7:0]);
    end
  end

  // line store
  logic [LS_ROWS*WORD_W-1:0] ls_rd, ls_wr;
  logic [WORD_W-1:0]         col_vec [MAX_KERNEL];

  nic_linebuf #(
    .DEPTH (LINE_MAX),
    .WIDTH (LS_ROWS * WORD_W)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (cc[AW-1:0]),
    .rd_data_o (ls_rd),
    .wr_en_i   (state_q == ST_LOAD),
    .wr_addr_i (cur_col_q[AW-1:0]),
    .wr_data_i (ls_wr)
  );

  // oldest row first, current pixel last; store shifts one row down
  always_comb begin
    col_vec[MAX_KERNEL-1] = word_q;
    for (int k = 0; k < MAX_KERNEL - 1; k++) begin
      col_vec[MAX_KERNEL-2-k] = ls_rd[k*WORD_W +: WORD_W];
    end
    ls_wr = ls_rd;
    for (int k = LS_ROWS - 1; k >= 1; k--) begin
      ls_wr[k*WORD_W +: WORD_W] = ls_rd[(k-1)*WORD_W +: WORD_W];
    end
    ls_wr[WORD_W-1:0] = word_q;
  end

  // window registers
  logic [WORD_W-1:0] win_q [NWIN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NWIN; i++) win_q[i] <= '0;
    end else if (state_q == ST_LOAD) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int x = 0; x < MAX_KERNEL - 1; x++) begin
          win_q[r*MAX_KERNEL+x] <= win_q[r*MAX_KERNEL+x+1];
        end
        win_q[r*MAX_KERNEL+MAX_KERNEL-1] <= col_vec[r];
      end
    end
  end

  // tap walk selection
  logic [3*CFG_DATA_W-1:0]   taps_all;
  logic [WIN_IW-1:0]         tidx, widx;
  logic signed [TAP_W-1:0]   tap;
  logic [WORD_W-1:0]         ent;
  logic                      last_tap, at_origin;

  assign taps_all  = {coef_c_q, coef_b_q, coef_a_q};
  assign tidx      = WIN_IW'(int'(y_q) * MAX_KERNEL + int'(x_q));
  assign widx      = WIN_IW'((int'(r0) + int'(y_q)) * MAX_KERNEL + int'(c0) + int'(x_q));
  assign tap       = $signed(taps_all[int'(tidx)*TAP_W +: TAP_W]);
  assign ent       = win_q[widx];
  assign last_tap  = (y_q == kh - 3'd1) && (x_q == kw - 3'd1);
  assign at_origin = (y_q == oy) && (x_q == ox);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOAD;
      ST_LOAD: state_d = emit_q ? ST_MAC : ST_IDLE;
      ST_MAC:  if (last_tap) state_d = ST_DVLD;
      ST_DVLD: state_d = ST_DIV;
      ST_DIV:  if (dcnt_q == DCW'(ACC_W - 2)) state_d = ST_DONE;
      ST_DONE: if (merge_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      rows_q  <= '0;
      y_q     <= '0;
      x_q     <= '0;
      dcnt_q  <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        col_q  <= col_d;
        rows_q <= rows_d;
        emit_q <= emit_now;
      end
      if (state_q == ST_LOAD) begin
        y_q <= '0;
        x_q <= '0;
      end else if (state_q == ST_MAC) begin
        if (x_q == kw - 3'd1) begin
          x_q <= '0;
          y_q <= y_q + 3'd1;
        end else begin
          x_q <= x_q + 3'd1;
        end
      end
      if (state_q == ST_DVLD) begin
        dcnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q + DCW'(1);
      end
    end
  end

  // per-request payload and tap sum
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q    <= word_in;
      cur_col_q <= cc;
      row_end_q <= row_end_now;
    end
    if (state_q == ST_LOAD) begin
      dsum_q <= '0;
    end else if (state_q == ST_MAC) begin
      dsum_q <= dsum_q + DW'(tap);
    end
  end

  // lanes
  lane_ctrl_t        lctrl;
  logic [SAMPLE_BITS-1:0] lane_res [4];

  assign lctrl.clr      = (state_q == ST_LOAD);
  assign lctrl.mac      = (state_q == ST_MAC);
  assign lctrl.origin   = at_origin;
  assign lctrl.div_ld   = (state_q == ST_DVLD);
  assign lctrl.div_step = (state_q == ST_DIV);

  for (genvar c = 0; c < 4; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      logic [1:0] op;
      assign op = (c > int'(layout_q[1:0])) ? OP_NOP : layout_q[2*c+3 -: 2];
      nic_lane #(
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .ctrl_i   (lctrl),
        .sample_i (ent[c*SAMPLE_BITS +: SAMPLE_BITS]),
        .tap_i    (tap),
        .dsum_i   (dsum_q),
        .op_i     (op),
        .wide_i   (wide_q),
        .res_o    (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  nic_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .res_i       (lane_res),
    .row_end_i   (row_end_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/nic_linebuf.sv
// Line store: one entry per column holding the previous kernel rows.
// Depends on nothing but the clock; registered read port.
module nic_linebuf #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/nic_lane.sv
// One channel lane: multiply-accumulate over the kernel, bit-serial divide
// by the tap sum, then clamp; copy mode passes the origin sample. Depends on nic_pkg.
module nic_lane #(
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  nic_pkg::lane_ctrl_t           ctrl_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic signed [nic_pkg::TAP_W-1:0] tap_i,
  input  logic signed [7+$clog2(MAX_KERNEL*MAX_KERNEL):0] dsum_i,
  input  logic [1:0]                    op_i,
  input  logic                          wide_i,
  output logic [SAMPLE_BITS-1:0]        res_o
);
  import nic_pkg::*;

  localparam int DW    = 8 + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int ACC_W = SAMPLE_BITS + 8 + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int QW    = ACC_W - 1;
  localparam int PW    = SAMPLE_BITS + TAP_W + 1;

  logic signed [ACC_W-1:0] acc_q;
  logic [SAMPLE_BITS-1:0]  copy_q;
  logic [QW-1:0]           quo_q;
  logic [DW-1:0]           rem_q;
  logic signed [PW-1:0]    prod;
  logic [DW-1:0]           trial;
  logic [QW-1:0]           val;
  logic [QW-1:0]           smax;

  assign prod = $signed({1'b0, sample_i}) * tap_i;

  // accumulate and catch the origin sample
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.mac) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
    if (ctrl_i.mac && ctrl_i.origin) begin
      copy_q <= sample_i;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign trial = {rem_q[DW-2:0], quo_q[QW-1]};
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_ld) begin
      quo_q <= acc_q[QW-1:0];
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      if (trial >= DW'(dsum_i)) begin
        rem_q <= trial - DW'(dsum_i);
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  // normalize, clamp, select
  assign smax = wide_i ? QW'({SAMPLE_BITS{1'b1}}) : QW'(8'hFF);
  assign val  = (dsum_i > 0) ? quo_q : acc_q[QW-1:0];

  always_comb begin
    res_o = '0;
    unique case (op_i)
      OP_COPY: res_o = copy_q;
      OP_CONV: begin
        if (acc_q > 0) begin
          res_o = (val > smax) ? smax[SAMPLE_BITS-1:0] : val[SAMPLE_BITS-1:0];
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

### rtl/nic_merge.sv
// Merge stage: gathers lane results into one output request and holds it
// in the output register until taken. Depends on nic_pkg.
module nic_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [SAMPLE_BITS-1:0] res_i [4],
  input  logic                   row_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output nic_pkg::pix_out_t      out_data_o
);
  import nic_pkg::*;

  logic     valid_q, valid_d;
  pix_out_t data_q;

  // output valid
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q.res_ch0 <= FIELD_W'(res_i[0]);
      data_q.res_ch1 <= FIELD_W'(res_i[1]);
      data_q.res_ch2 <= FIELD_W'(res_i[2]);
      data_q.res_ch3 <= FIELD_W'(res_i[3]);
      data_q.row_end <= row_end_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/nic_checker.sv
// Port-level checks for the normalized image convolution top level.
// Depends on nic_pkg; bound to normalized_image_convolution below.
module nic_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input nic_pkg::pix_out_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // block is busy the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work");

endmodule

bind normalized_image_convolution nic_checker u_nic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
